// ----- sv/dsws_pkg.sv -----
// Shared types, constants and the divider step for the DDS setup word sequencer.
`default_nettype none
package dsws_pkg;

	typedef enum logic [1:0] {
		WAVE_OFF    = 2'd0,
		WAVE_SINE   = 2'd1,
		WAVE_TRI    = 2'd2,
		WAVE_SQUARE = 2'd3
	} wave_t;

	// Configuration register indexes
	localparam logic REG_TUNING_MULT = 1'b0;
	localparam logic REG_HALF_CLOCK  = 1'b1;

	localparam logic [7:0]  TUNING_MULT_RST = 8'd33;
	localparam logic [15:0] HALF_CLOCK_RST  = 16'd31250;

	localparam int FREQ_W = 14;
	localparam int MULT_W = 8;
	localparam int TW_W   = FREQ_W + MULT_W;
	localparam int QUO_W  = 16;
	localparam int DIV_BITS_PER_STAGE = 4;

	// Command words
	localparam logic [15:0] WORD_RESET    = 16'h2100;
	localparam logic [15:0] WORD_FREQ_TAG = 16'h4000;
	localparam logic [15:0] WORD_PHASE_LO = 16'hCC00;
	localparam logic [15:0] WORD_PHASE_0  = 16'hC000;
	localparam logic [15:0] WORD_SLEEP    = 16'h20C0;
	localparam logic [15:0] WORD_SINE     = 16'h2000;
	localparam logic [15:0] WORD_TRI      = 16'h2002;

	// Beat positions within one five-word run
	localparam logic [2:0] BEAT_RESET = 3'd0;
	localparam logic [2:0] BEAT_LO    = 3'd1;
	localparam logic [2:0] BEAT_HI    = 3'd2;
	localparam logic [2:0] BEAT_PHASE = 3'd3;
	localparam logic [2:0] BEAT_CTRL  = 3'd4;

	typedef struct packed {
		wave_t              wave;
		logic [TW_W-1:0]    tw;    // frequency times tuning multiplier
		logic [FREQ_W-1:0]  div;   // divisor (frequency)
		logic [FREQ_W-1:0]  rem;   // partial remainder
		logic [QUO_W-1:0]   num;   // dividend bits still to consume, top first
		logic [QUO_W-1:0]   quo;   // quotient bits, shifted in from the bottom
	} stage_t;

	// Four restoring division steps. A zero divisor yields all-ones quotient bits.
	function automatic stage_t div_stage(input stage_t st);
		stage_t              r;
		logic [FREQ_W:0]     trial;
		logic [FREQ_W-1:0]   rem;
		logic [DIV_BITS_PER_STAGE-1:0] q;
		rem = st.rem;
		q   = '0;
		for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
			trial = {rem, st.num[QUO_W-1-i]};
			if (trial >= {1'b0, st.div}) begin
				trial = trial - {1'b0, st.div};
				q[DIV_BITS_PER_STAGE-1-i] = 1'b1;
			end
			rem = trial[FREQ_W-1:0];
		end
		r     = st;
		r.rem = rem;
		r.num = {st.num[QUO_W-DIV_BITS_PER_STAGE-1:0], {DIV_BITS_PER_STAGE{1'b0}}};
		r.quo = {st.quo[QUO_W-DIV_BITS_PER_STAGE-1:0], q};
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/dsws_word_emitter.sv -----
// Holds one finished request and plays out its five command words as beats.
`default_nettype none
module dsws_word_emitter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire dsws_pkg::stage_t in_item,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [39:0]          m_tdata,   // command_word, square_enable, square_compare, pad
	output logic                 m_tlast
);
	import dsws_pkg::*;

	logic        busy_q;
	logic [2:0]  beat_q;
	stage_t      item_q;
	logic [15:0] word;
	logic        is_sq;
	logic        fetch;

	assign fetch    = busy_q && m_tready && (beat_q == BEAT_CTRL);
	assign in_ready = !busy_q || fetch;
	assign is_sq    = (item_q.wave == WAVE_SQUARE);
	assign m_tvalid = busy_q;
	assign m_tlast  = (beat_q == BEAT_CTRL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= BEAT_RESET;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			beat_q <= BEAT_RESET;
		end else if (busy_q && m_tready) begin
			if (beat_q == BEAT_CTRL) begin
				busy_q <= 1'b0;
			end else begin
				beat_q <= beat_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
	end

	always_comb begin
		logic tuned;
		tuned = (item_q.wave == WAVE_SINE) || (item_q.wave == WAVE_TRI);
		case (beat_q)
			BEAT_RESET: word = WORD_RESET;
			BEAT_LO:    word = tuned ? (WORD_FREQ_TAG | {2'b00, item_q.tw[FREQ_W-1:0]})
			                         : WORD_FREQ_TAG;
			BEAT_HI:    word = tuned ? (WORD_FREQ_TAG |
			                            {2'b00, {(2*FREQ_W-TW_W){1'b0}}, item_q.tw[TW_W-1:FREQ_W]})
			                         : WORD_FREQ_TAG;
			BEAT_PHASE: word = tuned ? WORD_PHASE_0 : WORD_PHASE_LO;
			BEAT_CTRL: begin
				case (item_q.wave)
					WAVE_SINE: word = WORD_SINE;
					WAVE_TRI:  word = WORD_TRI;
					default:   word = WORD_SLEEP;
				endcase
			end
			default:    word = WORD_RESET;
		endcase
	end

	assign m_tdata = {7'd0,
	                  (m_tlast && is_sq) ? item_q.quo : 16'd0,
	                  m_tlast && is_sq,
	                  word};

endmodule
`default_nettype wire

// ----- sv/dds_setup_word_sequencer.sv -----
// Top level: request pipeline with tuning multiply and staged divider, then word emitter.
//
// Requests enter on the s_ channel: s_tuser carries the waveform mode, s_tdata the
// frequency in hertz. Each request leaves on the m_ channel as five 16-bit command
// beats; m_tlast marks the fifth, which also carries the square timer enable and
// compare value. Configuration is written through wr_en / wr_index / wr_data:
// index 0 is the tuning multiplier, index 1 the timer half clock.
// Path: an accepted request is registered in stage one, then passes stages two to
// four and the emitter register before its first beat is valid; a low m_tready can
// hold it anywhere along the way. The quotient comes out of a restoring divider that
// settles four bits in each of the four stages.
// Throughput: the emitter takes a new request only as the last beat of its run
// is accepted; the pipeline takes a new request every cycle while it has room, so
// up to four further requests queue behind the run being played out.
// Reset clears all valid bits and the beat counter and restores the register
// defaults (multiplier 33, half clock 31250). When the receiver holds m_tready low
// the current beat holds and the stages fill, then s_tready drops; nothing is lost.
`default_nettype none
module dds_setup_word_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [15:0] wr_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // frequency, pad
	input  wire logic [1:0]  s_tuser,   // waveform
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // command_word, square_enable, square_compare, pad
	output logic             m_tlast
);
	import dsws_pkg::*;

	logic [MULT_W-1:0] tuning_mult_q;
	logic [15:0]       half_clock_q;

	stage_t st_s1, st_s2, st_s3, st_s4;
	logic   v_s1, v_s2, v_s3, v_s4;
	logic   rdy1, rdy2, rdy3, rdy4;
	logic   emit_ready;
	stage_t entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuning_mult_q <= TUNING_MULT_RST;
			half_clock_q  <= HALF_CLOCK_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_TUNING_MULT: tuning_mult_q <= wr_data[MULT_W-1:0];
				REG_HALF_CLOCK:  half_clock_q  <= wr_data;
				default:         tuning_mult_q <= tuning_mult_q;
			endcase
		end
	end

	// Stage readiness: a stage takes a new beat when empty or when it moves on
	assign rdy4     = !v_s4 || emit_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_comb begin
		stage_t st0;
		st0.wave = wave_t'(s_tuser);
		st0.tw   = TW_W'(s_tdata[FREQ_W-1:0] * tuning_mult_q);
		st0.div  = s_tdata[FREQ_W-1:0];
		st0.rem  = '0;
		st0.num  = half_clock_q;
		st0.quo  = '0;
		entry    = div_stage(st0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) st_s1 <= entry;
		if (rdy2 && v_s1)     st_s2 <= div_stage(st_s1);
		if (rdy3 && v_s2)     st_s3 <= div_stage(st_s2);
		if (rdy4 && v_s3)     st_s4 <= div_stage(st_s3);
	end

	dsws_word_emitter u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_ready (emit_ready),
		.in_item  (st_s4),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Timer fields stay zero on every beat but the last
	a_cmp_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[32:16] == 17'd0)
		else $error("timer fields set before last beat");

	// A run, once started, keeps its beats coming until the last one
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("run broken off before last beat");

	// An accepted request occupies the first stage on the next cycle
	a_entry_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted request lost at entry");

	// Compare is only given with the square enable
	a_cmp_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[16] |-> m_tdata[32:17] == 16'd0)
		else $error("compare without square enable");

endmodule
`default_nettype wire
